[rtl/hks_pkg.sv]
// Shared types, constants and codes for the hashed key set engine.
package hks_pkg;

   localparam int KEY_W      = 64;
   localparam int BUCKETS    = 1024;
   localparam int WAYS       = 4;
   localparam int BKT_W      = $clog2(BUCKETS);
   localparam int DIV_W      = $clog2(BUCKETS + 1);
   localparam int FILL_W     = $clog2(WAYS + 1);
   localparam int ENTRIES    = BUCKETS * WAYS;
   localparam int ENTRY_AW   = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int BCNT_W     = 11;
   localparam int CMD_W      = 3;
   localparam int STAT_W     = 2;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int MOD_STEP   = 4;
   localparam int MOD_ITERS  = KEY_W / MOD_STEP;
   localparam int MOD_CNT_W  = $clog2(MOD_ITERS);
   localparam logic [BCNT_W-1:0] BCNT_RESET = BCNT_W'(1021);

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT   = 3'd0,
      CMD_DISCARD  = 3'd1,
      CMD_CONTAINS = 3'd2,
      CMD_POP      = 3'd3,
      CMD_CLEAR    = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_POP_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_FILL_RD,
      ST_FILL_GET,
      ST_WALK,
      ST_SHIFT,
      ST_POP_SCAN,
      ST_POP_CHK,
      ST_POP_RD,
      ST_POP_GET,
      ST_RESP
   } state_type;

endpackage

[rtl/hks_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
module hks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/hks_mod_unit.sv]
// Iterative remainder unit: key modulo bucket count, a few quotient bits per cycle.
module hks_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hks_pkg::KEY_W-1:0]   dividend,
   input  logic [hks_pkg::DIV_W-1:0]   divisor,
   output logic                        done,
   output logic [hks_pkg::DIV_W-1:0]   remainder
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [hks_pkg::MOD_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [hks_pkg::KEY_W-1:0]         shreg_ff, shreg_in;
   logic [hks_pkg::DIV_W-1:0]         rem_ff, rem_in;
   logic [hks_pkg::DIV_W-1:0]         div_ff, div_in;
   logic [hks_pkg::DIV_W-1:0]         step_rem;
   logic [hks_pkg::DIV_W:0]           trial;

   // Restoring steps on a remainder that always stays below the divisor.
   always_comb begin
      step_rem = rem_ff;
      trial    = '0;
      for (int i = 0; i < hks_pkg::MOD_STEP; i++) begin
         trial = {step_rem, shreg_ff[hks_pkg::KEY_W-1-i]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         step_rem = trial[hks_pkg::DIV_W-1:0];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shreg_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = step_rem;
         shreg_in = shreg_ff << hks_pkg::MOD_STEP;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == hks_pkg::MOD_CNT_W'(hks_pkg::MOD_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[rtl/hashed_key_set_engine.sv]
// Top level of the hashed key set engine: sequencer, register port and memories.
//
// A request transaction carries a command (insert, discard, contains, pop,
// clear) and a 64-bit key. The engine takes one request at a time: req_ready
// is high only while the engine is idle, and exactly one response
// transaction follows each request. The response holds its fields stable
// until rsp_ready is seen; the engine accepts no new request until then.
// Insert, discard and contains first run the key through the shared
// remainder unit, four bits a cycle, then read the bucket fill count and
// walk the bucket one entry a cycle. Pop scans the fill counts from bucket
// zero and takes the last entry of the first non-empty bucket. Clear
// sweeps all 1024 fill counts, one a cycle. After reset the same sweep
// runs, during which no request is accepted; register writes are taken at
// any time. The bucket_count register sits at byte address 0 and resets
// to 1021.
module hashed_key_set_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [hks_pkg::CMD_W-1:0]    req_cmd,
   input  logic [hks_pkg::KEY_W-1:0]    req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hks_pkg::STAT_W-1:0]   rsp_status,
   output logic                         rsp_found,
   output logic [hks_pkg::KEY_W-1:0]    rsp_popped_key,
   output logic [hks_pkg::CNT_W-1:0]    rsp_element_total,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [hks_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [hks_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [hks_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   hks_pkg::state_type              state_ff, state_in;
   logic [hks_pkg::BCNT_W-1:0]      bcnt_ff, bcnt_in;
   logic [hks_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [hks_pkg::KEY_W-1:0]       key_ff, key_in;
   logic [hks_pkg::BKT_W-1:0]       bkt_ff, bkt_in;
   logic [hks_pkg::FILL_W-1:0]      fill_ff, fill_in;
   logic [hks_pkg::FILL_W-1:0]      way_ff, way_in;
   logic [hks_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            clr_rsp_ff, clr_rsp_in;
   logic [hks_pkg::STAT_W-1:0]      status_ff, status_in;
   logic                            found_ff, found_in;
   logic [hks_pkg::KEY_W-1:0]       popped_ff, popped_in;

   logic                            req_fire;
   logic                            csr_write;
   logic [hks_pkg::DIV_W-1:0]       divisor;
   logic                            mod_start;
   logic                            mod_done;
   logic [hks_pkg::DIV_W-1:0]       mod_rem;
   logic                            walk_end;
   logic                            key_hit;
   logic                            last_bkt;
   logic [hks_pkg::ENTRY_AW-1:0]    bkt_base;

   logic                            fill_we;
   logic [hks_pkg::BKT_W-1:0]       fill_waddr;
   logic [hks_pkg::FILL_W-1:0]      fill_wdata;
   logic [hks_pkg::FILL_W-1:0]      fill_rdata;
   logic                            ent_we;
   logic [hks_pkg::ENTRY_AW-1:0]    ent_waddr;
   logic [hks_pkg::KEY_W-1:0]       ent_wdata;
   logic [hks_pkg::ENTRY_AW-1:0]    ent_raddr;
   logic [hks_pkg::KEY_W-1:0]       ent_rdata;

   assign req_ready = (state_ff == hks_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (state_ff == hks_pkg::ST_RESP);

   assign rsp_status        = status_ff;
   assign rsp_found         = found_ff;
   assign rsp_popped_key    = popped_ff;
   assign rsp_element_total = count_ff;

   // Register port: one register, always ready.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? '0 : hks_pkg::CSR_DW'(bcnt_ff);

   always_comb begin
      bcnt_in = csr_write ? csr_pwdata[hks_pkg::BCNT_W-1:0] : bcnt_ff;
   end

   // A count of zero acts as one, and a count above the bucket total saturates.
   always_comb begin
      if (bcnt_ff == '0) begin
         divisor = hks_pkg::DIV_W'(1);
      end else if (hks_pkg::DIV_W'(bcnt_ff) > hks_pkg::DIV_W'(hks_pkg::BUCKETS)) begin
         divisor = hks_pkg::DIV_W'(hks_pkg::BUCKETS);
      end else begin
         divisor = hks_pkg::DIV_W'(bcnt_ff);
      end
   end

   assign mod_start = req_fire && (req_cmd == hks_pkg::CMD_INSERT ||
                                   req_cmd == hks_pkg::CMD_DISCARD ||
                                   req_cmd == hks_pkg::CMD_CONTAINS);

   hks_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_key),
      .divisor   (divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign bkt_base = hks_pkg::ENTRY_AW'(bkt_ff) * hks_pkg::ENTRY_AW'(hks_pkg::WAYS);
   assign walk_end = (way_ff >= fill_ff);
   assign key_hit  = (ent_rdata == key_ff);
   assign last_bkt = (bkt_ff == hks_pkg::BKT_W'(hks_pkg::BUCKETS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hks_pkg::ST_CLEAR: begin
            if (last_bkt) begin
               state_in = clr_rsp_ff ? hks_pkg::ST_RESP : hks_pkg::ST_IDLE;
            end
         end
         hks_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority case (req_cmd)
                  hks_pkg::CMD_INSERT,
                  hks_pkg::CMD_DISCARD,
                  hks_pkg::CMD_CONTAINS: state_in = hks_pkg::ST_DIV;
                  hks_pkg::CMD_POP: begin
                     state_in = (count_ff == '0) ? hks_pkg::ST_RESP : hks_pkg::ST_POP_SCAN;
                  end
                  hks_pkg::CMD_CLEAR:    state_in = hks_pkg::ST_CLEAR;
                  default:               state_in = hks_pkg::ST_RESP;
               endcase
            end
         end
         hks_pkg::ST_DIV: begin
            if (mod_done) begin
               state_in = hks_pkg::ST_FILL_RD;
            end
         end
         hks_pkg::ST_FILL_RD:  state_in = hks_pkg::ST_FILL_GET;
         hks_pkg::ST_FILL_GET: state_in = hks_pkg::ST_WALK;
         hks_pkg::ST_WALK: begin
            if (walk_end) begin
               state_in = hks_pkg::ST_RESP;
            end else if (key_hit) begin
               state_in = (cmd_ff == hks_pkg::CMD_DISCARD) ? hks_pkg::ST_SHIFT
                                                           : hks_pkg::ST_RESP;
            end
         end
         hks_pkg::ST_SHIFT: begin
            if (hks_pkg::FILL_W'(way_ff + 1'b1) >= fill_ff) begin
               state_in = hks_pkg::ST_RESP;
            end
         end
         hks_pkg::ST_POP_SCAN: state_in = hks_pkg::ST_POP_CHK;
         hks_pkg::ST_POP_CHK: begin
            state_in = (fill_rdata != '0) ? hks_pkg::ST_POP_RD : hks_pkg::ST_POP_SCAN;
         end
         hks_pkg::ST_POP_RD:  state_in = hks_pkg::ST_POP_GET;
         hks_pkg::ST_POP_GET: state_in = hks_pkg::ST_RESP;
         hks_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = hks_pkg::ST_IDLE;
            end
         end
         default: state_in = hks_pkg::ST_IDLE;
      endcase
   end

   // Datapath, memory controls and result registers.
   always_comb begin
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      bkt_in     = bkt_ff;
      fill_in    = fill_ff;
      way_in     = way_ff;
      count_in   = count_ff;
      clr_rsp_in = clr_rsp_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      popped_in  = popped_ff;
      fill_we    = 1'b0;
      fill_waddr = bkt_ff;
      fill_wdata = '0;
      ent_we     = 1'b0;
      ent_waddr  = bkt_base + hks_pkg::ENTRY_AW'(way_ff);
      ent_wdata  = key_ff;
      ent_raddr  = bkt_base;
      unique case (state_ff)
         hks_pkg::ST_CLEAR: begin
            fill_we = 1'b1;
            bkt_in  = bkt_ff + 1'b1;
         end
         hks_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_cmd;
               key_in    = req_key;
               bkt_in    = '0;
               status_in = hks_pkg::STAT_OK;
               found_in  = 1'b0;
               popped_in = '0;
               clr_rsp_in = 1'b0;
               if (req_cmd == hks_pkg::CMD_POP && count_ff == '0) begin
                  status_in = hks_pkg::STAT_POP_EMPTY;
               end
               if (req_cmd == hks_pkg::CMD_CLEAR) begin
                  count_in   = '0;
                  clr_rsp_in = 1'b1;
               end
            end
         end
         hks_pkg::ST_DIV: begin
            if (mod_done) begin
               bkt_in = mod_rem[hks_pkg::BKT_W-1:0];
            end
         end
         hks_pkg::ST_FILL_RD: begin
         end
         hks_pkg::ST_FILL_GET: begin
            fill_in = fill_rdata;
            way_in  = '0;
         end
         hks_pkg::ST_WALK: begin
            ent_raddr = bkt_base + hks_pkg::ENTRY_AW'(way_ff + 1'b1);
            if (walk_end) begin
               if (cmd_ff == hks_pkg::CMD_INSERT) begin
                  if (fill_ff >= hks_pkg::FILL_W'(hks_pkg::WAYS)) begin
                     status_in = hks_pkg::STAT_FULL;
                  end else begin
                     ent_we     = 1'b1;
                     ent_waddr  = bkt_base + hks_pkg::ENTRY_AW'(fill_ff);
                     fill_we    = 1'b1;
                     fill_wdata = fill_ff + 1'b1;
                     count_in   = count_ff + 1'b1;
                  end
               end
            end else if (key_hit) begin
               found_in = 1'b1;
            end else begin
               way_in = way_ff + 1'b1;
            end
         end
         hks_pkg::ST_SHIFT: begin
            // The entry behind the removed key moves up one place per cycle.
            ent_raddr = bkt_base + hks_pkg::ENTRY_AW'(way_ff + 2'd2);
            if (hks_pkg::FILL_W'(way_ff + 1'b1) < fill_ff) begin
               ent_we    = 1'b1;
               ent_wdata = ent_rdata;
               way_in    = way_ff + 1'b1;
            end else begin
               fill_we    = 1'b1;
               fill_wdata = fill_ff - 1'b1;
               count_in   = count_ff - 1'b1;
            end
         end
         hks_pkg::ST_POP_SCAN: begin
         end
         hks_pkg::ST_POP_CHK: begin
            fill_in = fill_rdata;
            if (fill_rdata == '0) begin
               bkt_in = bkt_ff + 1'b1;
            end
         end
         hks_pkg::ST_POP_RD: begin
            ent_raddr  = bkt_base + hks_pkg::ENTRY_AW'(fill_ff - 1'b1);
            fill_we    = 1'b1;
            fill_wdata = fill_ff - 1'b1;
            count_in   = count_ff - 1'b1;
         end
         hks_pkg::ST_POP_GET: begin
            popped_in = ent_rdata;
            found_in  = 1'b1;
         end
         hks_pkg::ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   hks_ram #(
      .WIDTH (hks_pkg::FILL_W),
      .DEPTH (hks_pkg::BUCKETS),
      .AW    (hks_pkg::BKT_W)
   ) u_fill_ram (
      .clock (clock),
      .we    (fill_we),
      .waddr (fill_waddr),
      .wdata (fill_wdata),
      .raddr (bkt_in),
      .rdata (fill_rdata)
   );

   hks_ram #(
      .WIDTH (hks_pkg::KEY_W),
      .DEPTH (hks_pkg::ENTRIES),
      .AW    (hks_pkg::ENTRY_AW)
   ) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= hks_pkg::ST_CLEAR;
         bcnt_ff    <= hks_pkg::BCNT_RESET;
         bkt_ff     <= '0;
         count_ff   <= '0;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bcnt_ff    <= bcnt_in;
         bkt_ff     <= bkt_in;
         count_ff   <= count_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      fill_ff   <= fill_in;
      way_ff    <= way_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      popped_ff <= popped_in;
   end

endmodule

[rtl/hks_checker.sv]
// Port-level checks for the hashed key set engine, bound to the top level.
module hks_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [hks_pkg::STAT_W-1:0]   rsp_status,
   input logic                         rsp_found,
   input logic [hks_pkg::KEY_W-1:0]    rsp_popped_key,
   input logic [hks_pkg::CNT_W-1:0]    rsp_element_total
);

   // One transaction at a time: a pending response blocks new requests.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("engine ready right after taking a request");

   // A pop on an empty set reports nothing removed and an empty set.
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == hks_pkg::STAT_POP_EMPTY) |->
         (!rsp_found && rsp_element_total == '0 && rsp_popped_key == '0))
      else $error("empty pop with inconsistent result fields");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == hks_pkg::STAT_FULL) |-> !rsp_found)
      else $error("refused insert reports the key as present");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_element_total)))
      else $error("response dropped or changed while stalled");

endmodule

bind hashed_key_set_engine hks_checker u_hks_checker (.*);

[sim/tb_hashed_key_set_engine.sv]
// Self-checking testbench for the hashed key set engine with a built-in set predictor.
module tb_hashed_key_set_engine;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [hks_pkg::CMD_W-1:0]         req_cmd = '0;
   logic [hks_pkg::KEY_W-1:0]         req_key = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [hks_pkg::STAT_W-1:0]        rsp_status;
   logic                              rsp_found;
   logic [hks_pkg::KEY_W-1:0]         rsp_popped_key;
   logic [hks_pkg::CNT_W-1:0]         rsp_element_total;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [hks_pkg::CSR_AW-1:0]        csr_paddr = '0;
   logic [hks_pkg::CSR_DW-1:0]        csr_pwdata = '0;
   logic [hks_pkg::CSR_DW-1:0]        csr_prdata;
   logic                              csr_pready;

   typedef struct packed {
      logic [hks_pkg::STAT_W-1:0] status;
      logic                       found;
      logic [hks_pkg::KEY_W-1:0]  popped_key;
      logic [hks_pkg::CNT_W-1:0]  element_total;
   } set_result_type;

   typedef struct {
      logic [hks_pkg::CMD_W-1:0] cmd;
      logic [hks_pkg::KEY_W-1:0] key;
      logic                      typed;
      set_result_type            res;
   } stim_row_type;

   // Predictor state.
   logic [hks_pkg::KEY_W-1:0]  slot_key [hks_pkg::BUCKETS][hks_pkg::WAYS];
   int unsigned                slot_fill [hks_pkg::BUCKETS];
   int unsigned                held_total;
   logic [hks_pkg::BCNT_W-1:0] modulus_reg;

   set_result_type pending_results[$];
   int             error_count = 0;
   int             rsp_seen = 0;
   bit             hold_rsp = 1'b0;
   bit             rand_idle = 1'b1;
   logic [hks_pkg::KEY_W-1:0] recent_keys[$];

   hashed_key_set_engine dut (.*);

   always #2 clock = ~clock;

   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [hks_pkg::KEY_W-1:0] got,
                                  input logic [hks_pkg::KEY_W-1:0] want);
      $display("MISMATCH %s: got %0h expected %0h (response %0d)", what, got, want, rsp_seen);
      error_count++;
   endtask

   function automatic int unsigned bucket_of(input logic [hks_pkg::KEY_W-1:0] key);
      int unsigned n;
      n = 32'(modulus_reg);
      if (n == 0) n = 1;
      if (n > hks_pkg::BUCKETS) n = hks_pkg::BUCKETS;
      return 32'(key % hks_pkg::KEY_W'(n));
   endfunction

   function automatic set_result_type predict_set_op(input logic [hks_pkg::CMD_W-1:0] cmd,
                                                     input logic [hks_pkg::KEY_W-1:0] key);
      set_result_type r;
      int unsigned b;
      int pos;
      r = '0;
      pos = -1;
      b = 0;
      if (cmd <= hks_pkg::CMD_CONTAINS) begin
         b = bucket_of(key);
         for (int w = int'(slot_fill[b]) - 1; w >= 0; w--)
            if (slot_key[b][w] == key) pos = w;
      end
      case (cmd)
         hks_pkg::CMD_INSERT: begin
            if (pos >= 0) r.found = 1'b1;
            else if (slot_fill[b] >= hks_pkg::WAYS) r.status = hks_pkg::STAT_FULL;
            else begin
               slot_key[b][slot_fill[b]] = key;
               slot_fill[b]++;
               held_total++;
            end
         end
         hks_pkg::CMD_DISCARD: begin
            if (pos >= 0) begin
               r.found = 1'b1;
               for (int w = pos; w + 1 < slot_fill[b]; w++) slot_key[b][w] = slot_key[b][w+1];
               slot_fill[b]--;
               held_total--;
            end
         end
         hks_pkg::CMD_CONTAINS: r.found = (pos >= 0);
         hks_pkg::CMD_POP: begin
            r.status = hks_pkg::STAT_POP_EMPTY;
            for (int i = 0; i < hks_pkg::BUCKETS && held_total > 0; i++) begin
               if (slot_fill[i] > 0) begin
                  slot_fill[i]--;
                  r.popped_key = slot_key[i][slot_fill[i]];
                  held_total--;
                  r.found = 1'b1;
                  r.status = hks_pkg::STAT_OK;
                  break;
               end
            end
         end
         hks_pkg::CMD_CLEAR: begin
            foreach (slot_fill[i]) slot_fill[i] = 0;
            held_total = 0;
         end
         default: ;
      endcase
      r.element_total = hks_pkg::CNT_W'(held_total);
      return r;
   endfunction

   // Offers one request; the predictor runs when the transaction is accepted.
   task automatic send_request(input logic [hks_pkg::CMD_W-1:0] cmd,
                               input logic [hks_pkg::KEY_W-1:0] key,
                               input bit typed, input set_result_type res);
      set_result_type p;
      @(negedge clock);
      while (rand_idle && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_key <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = predict_set_op(cmd, key);
      if (typed && p != res)
         report_mismatch("directed table row",
                         hks_pkg::KEY_W'({p.status, p.found, p.element_total}),
                         hks_pkg::KEY_W'({res.status, res.found, res.element_total}));
      pending_results.push_back(p);
      if (cmd == hks_pkg::CMD_INSERT) recent_keys.push_back(key);
      if (recent_keys.size() > 24) void'(recent_keys.pop_front());
   endtask

   task automatic end_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain_results();
      end_requests();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_modulus(input logic [hks_pkg::CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      modulus_reg = value[hks_pkg::BCNT_W-1:0];
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (csr_prdata != hks_pkg::CSR_DW'(modulus_reg))
         report_mismatch("bucket_count readback", hks_pkg::KEY_W'(csr_prdata),
                         hks_pkg::KEY_W'(modulus_reg));
   endtask

   // Response side: random stalls, or a long hold while hold_rsp is set.
   always @(negedge clock) begin
      if (!reset) rsp_ready <= !hold_rsp && !(rand_idle && $urandom_range(99) < 19);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         set_result_type want;
         rsp_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("response with nothing pending",
                            hks_pkg::KEY_W'(rsp_element_total), '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status != want.status)
               report_mismatch("status", hks_pkg::KEY_W'(rsp_status),
                               hks_pkg::KEY_W'(want.status));
            if (rsp_found != want.found)
               report_mismatch("found", hks_pkg::KEY_W'(rsp_found),
                               hks_pkg::KEY_W'(want.found));
            if (rsp_popped_key != want.popped_key)
               report_mismatch("popped_key", rsp_popped_key, want.popped_key);
            if (rsp_element_total != want.element_total)
               report_mismatch("element_total", hks_pkg::KEY_W'(rsp_element_total),
                               hks_pkg::KEY_W'(want.element_total));
         end
      end
   end

   function automatic set_result_type mk(input logic [hks_pkg::STAT_W-1:0] s, input logic f,
                                         input logic [hks_pkg::KEY_W-1:0] k,
                                         input int unsigned n);
      set_result_type r;
      r.status = s;
      r.found = f;
      r.popped_key = k;
      r.element_total = hks_pkg::CNT_W'(n);
      return r;
   endfunction

   function automatic logic [hks_pkg::KEY_W-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   initial begin
      stim_row_type table_rows[$];
      logic [hks_pkg::KEY_W-1:0] k;
      logic [hks_pkg::CMD_W-1:0] c;
      int unsigned pick;
      int unsigned moduli[6] = '{1, 2, 0, 2047, 1024, 7};

      foreach (slot_fill[i]) slot_fill[i] = 0;
      held_total = 0;
      modulus_reg = hks_pkg::BCNT_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table at the reset modulus; typed rows follow directly from an empty set.
      table_rows.push_back('{hks_pkg::CMD_POP, '1, 1'b1, mk(hks_pkg::STAT_POP_EMPTY, 0, 0, 0)});
      table_rows.push_back('{hks_pkg::CMD_CONTAINS, 0, 1'b1, mk(hks_pkg::STAT_OK, 0, 0, 0)});
      table_rows.push_back('{hks_pkg::CMD_INSERT, 0, 1'b1, mk(hks_pkg::STAT_OK, 0, 0, 1)});
      table_rows.push_back('{hks_pkg::CMD_INSERT, '1, 1'b1, mk(hks_pkg::STAT_OK, 0, 0, 2)});
      table_rows.push_back('{hks_pkg::CMD_INSERT, 0, 1'b1, mk(hks_pkg::STAT_OK, 1, 0, 2)});
      table_rows.push_back('{hks_pkg::CMD_INSERT, 1021, 0, '0});
      table_rows.push_back('{hks_pkg::CMD_INSERT, 2042, 0, '0});
      table_rows.push_back('{hks_pkg::CMD_INSERT, 3063, 0, '0});
      table_rows.push_back('{hks_pkg::CMD_INSERT, 4084, 1'b1, mk(hks_pkg::STAT_FULL, 0, 0, 5)});
      table_rows.push_back('{hks_pkg::CMD_INSERT, 3063, 1'b1, mk(hks_pkg::STAT_OK, 1, 0, 5)});
      table_rows.push_back('{hks_pkg::CMD_CONTAINS, 2042, 0, '0});
      table_rows.push_back('{hks_pkg::CMD_DISCARD, 1021, 0, '0});
      table_rows.push_back('{hks_pkg::CMD_DISCARD, 77, 0, '0});
      table_rows.push_back('{hks_pkg::CMD_CONTAINS, 3063, 0, '0});
      table_rows.push_back('{hks_pkg::CMD_POP, 0, 0, '0});
      table_rows.push_back('{3'd5, 5, 0, '0});
      table_rows.push_back('{3'd6, 6, 0, '0});
      table_rows.push_back('{3'd7, '1, 0, '0});
      table_rows.push_back('{hks_pkg::CMD_CLEAR, 0, 1'b1, mk(hks_pkg::STAT_OK, 0, 0, 0)});
      table_rows.push_back('{hks_pkg::CMD_POP, 0, 1'b1, mk(hks_pkg::STAT_POP_EMPTY, 0, 0, 0)});
      foreach (table_rows[i])
         send_request(table_rows[i].cmd, table_rows[i].key, table_rows[i].typed,
                      table_rows[i].res);
      drain_results();

      // Held keys stay put when the modulus changes; a lookup under the new modulus misses them.
      send_request(hks_pkg::CMD_INSERT, 64'd1500, 0, '0);
      drain_results();
      write_modulus(2);
      for (int i = 0; i < 8; i++) send_request(hks_pkg::CMD_INSERT, 64'(i), 0, '0);
      send_request(hks_pkg::CMD_CONTAINS, 64'd1500, 0, '0);
      for (int i = 0; i < 5; i++) send_request(hks_pkg::CMD_POP, 0, 0, '0);
      send_request(hks_pkg::CMD_CLEAR, 0, 0, '0);
      drain_results();

      // Long receiver hold while requests keep coming.
      hold_rsp = 1'b1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end
         begin
            for (int i = 0; i < 6; i++) send_request(hks_pkg::CMD_INSERT, random_key(), 0, '0);
            end_requests();
         end
      join
      drain_results();

      // Random phases over several moduli, pops and clears kept rare since they are slow.
      foreach (moduli[m]) begin
         write_modulus(moduli[m]);
         rand_idle = (m != 3);
         for (int i = 0; i < 135; i++) begin
            pick = $urandom_range(99);
            if (recent_keys.size() > 0 && $urandom_range(1))
               k = recent_keys[$urandom_range(recent_keys.size() - 1)];
            else if ($urandom_range(3) == 0) k = 64'($urandom_range(40));
            else k = random_key();
            if (pick < 45) c = hks_pkg::CMD_INSERT;
            else if (pick < 68) c = hks_pkg::CMD_DISCARD;
            else if (pick < 90) c = hks_pkg::CMD_CONTAINS;
            else if (pick < 96) c = hks_pkg::CMD_POP;
            else if (pick < 98) c = hks_pkg::CMD_CLEAR;
            else c = hks_pkg::CMD_W'($urandom_range(7, 5));
            send_request(c, k, 0, '0);
         end
         drain_results();
      end
      write_modulus(32'hFFFF_FFFF);
      drain_results();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

[filelist.f]
rtl/hks_pkg.sv
rtl/hks_ram.sv
rtl/hks_mod_unit.sv
rtl/hashed_key_set_engine.sv
rtl/hks_checker.sv
sim/tb_hashed_key_set_engine.sv
